FILE: rtl/ehc_pkg.sv
// Shared constants, types and codes of the edge occurrence hash counter.
package ehc_pkg;

  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned COUNT_BITS  = 16;

  localparam int unsigned SLOT_W   = $clog2(TABLE_SLOTS);
  localparam int unsigned TOTAL_W  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned OFFS_W   = 24;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HALF_W   = KEY_W / 2;
  localparam int unsigned ENTRY_W  = KEY_W + COUNT_BITS;

  localparam logic [KEY_W-1:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [KEY_W-1:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;
  localparam int unsigned MIX_SHIFT_0 = 30;
  localparam int unsigned MIX_SHIFT_1 = 27;
  localparam int unsigned MIX_SHIFT_2 = 31;

  typedef enum logic [1:0] {
    OUT_COUNTED  = 2'd0,
    OUT_INSERTED = 2'd1,
    OUT_DROPPED  = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [COUNT_BITS-1:0] count;
  } slot_entry_t;

endpackage

FILE: rtl/ehc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module ehc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/edge_occurrence_hash_counter.sv
// Top level of the edge occurrence hash counter.
//
// Each accepted transaction carries one edge; the block hashes it with the
// splitmix64 finalizer on a single shared 32x32 multiplier (three partial
// products per 64-bit multiply) and then probes the 1024-slot table
// linearly, with a memory read state and a compare state per slot. The
// multiplier sequence and the single table read port hold the block, so it
// takes no new edge until it is through with the last one.
// After reset the block clears all 1024 slots of the table and holds its
// input stalled until that is done. A finished result waits in an output
// register, so the next edge is taken while the previous result is stalled.
module edge_occurrence_hash_counter
  import ehc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OFFS_W-1:0]     source_offset_i,
  input  logic [OFFS_W-1:0]     destination_offset_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            outcome_o,
  output logic [SLOT_W-1:0]     slot_index_o,
  output logic [COUNT_BITS-1:0] occurrences_o,
  output logic [TOTAL_W-1:0]    edges_held_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_LL,
    ST_MUL_HL,
    ST_MUL_LH,
    ST_XOR_SHIFT,
    ST_READ,
    ST_COMPARE,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [SLOT_W-1:0]     clear_q;
  logic [KEY_W-1:0]      key_q;
  logic [KEY_W-1:0]      mix_q;
  logic [KEY_W-1:0]      acc_q;
  logic                  pass_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [SLOT_W-1:0]     probe_q;
  logic [TOTAL_W-1:0]    total_q;
  outcome_e              res_outcome_q;
  logic [SLOT_W-1:0]     res_slot_q;
  logic [COUNT_BITS-1:0] res_count_q;
  logic                  out_valid_q;
  outcome_e              out_outcome_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic [COUNT_BITS-1:0] out_count_q;
  logic [TOTAL_W-1:0]    out_total_q;

  logic [KEY_W-1:0]      in_key;
  logic [KEY_W-1:0]      mul_const;
  logic [HALF_W-1:0]     mul_a;
  logic [HALF_W-1:0]     mul_b;
  logic [KEY_W-1:0]      product;
  logic [KEY_W-1:0]      shifted;
  logic [KEY_W-1:0]      final_mix;
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  slot_entry_t           ram_wdata;
  slot_entry_t           ram_rdata;
  logic                  slot_empty;
  logic                  slot_match;
  logic                  can_insert;
  logic [COUNT_BITS-1:0] count_next;

  ehc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(slot_q),
    .rdata_o(ram_rdata)
  );

  assign in_key = {8'h00, source_offset_i, 8'h00, destination_offset_i} + KEY_W'(1);

  assign mul_const = pass_q ? MIX_MUL_B : MIX_MUL_A;
  assign mul_a     = (state_q == ST_MUL_HL) ? mix_q[KEY_W-1:HALF_W] : mix_q[HALF_W-1:0];
  assign mul_b     = (state_q == ST_MUL_LH) ? mul_const[KEY_W-1:HALF_W]
                                            : mul_const[HALF_W-1:0];
  assign product   = KEY_W'(mul_a) * KEY_W'(mul_b);
  assign shifted   = pass_q ? (acc_q >> MIX_SHIFT_1) : (acc_q >> MIX_SHIFT_1);
  assign final_mix = acc_q ^ (acc_q >> MIX_SHIFT_2);

  assign slot_empty = (ram_rdata.key == '0);
  assign slot_match = (ram_rdata.key == key_q);
  assign can_insert = (total_q < TOTAL_W'(TABLE_SLOTS));
  assign count_next = (ram_rdata.count == '1) ? ram_rdata.count
                                              : ram_rdata.count + COUNT_BITS'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = '{key: key_q, count: count_next};
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clear_q;
      ram_wdata = '0;
    end else if (state_q == ST_COMPARE) begin
      if (slot_empty && can_insert) begin
        ram_we    = 1'b1;
        ram_wdata = '{key: key_q, count: COUNT_BITS'(1)};
      end else if (!slot_empty && slot_match) begin
        ram_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clear_q       <= '0;
      key_q         <= '0;
      mix_q         <= '0;
      acc_q         <= '0;
      pass_q        <= 1'b0;
      slot_q        <= '0;
      probe_q       <= '0;
      total_q       <= '0;
      res_outcome_q <= OUT_DROPPED;
      res_slot_q    <= '0;
      res_count_q   <= '0;
      out_valid_q   <= 1'b0;
      out_outcome_q <= OUT_DROPPED;
      out_slot_q    <= '0;
      out_count_q   <= '0;
      out_total_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clear_q <= clear_q + SLOT_W'(1);
          if (clear_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            key_q   <= in_key;
            mix_q   <= in_key ^ (in_key >> MIX_SHIFT_0);
            pass_q  <= 1'b0;
            state_q <= ST_MUL_LL;
          end
        end
        ST_MUL_LL: begin
          acc_q   <= product;
          state_q <= ST_MUL_HL;
        end
        ST_MUL_HL: begin
          acc_q[KEY_W-1:HALF_W] <= acc_q[KEY_W-1:HALF_W] + product[HALF_W-1:0];
          state_q               <= ST_MUL_LH;
        end
        ST_MUL_LH: begin
          acc_q[KEY_W-1:HALF_W] <= acc_q[KEY_W-1:HALF_W] + product[HALF_W-1:0];
          state_q               <= ST_XOR_SHIFT;
        end
        ST_XOR_SHIFT: begin
          if (!pass_q) begin
            mix_q   <= acc_q ^ shifted;
            pass_q  <= 1'b1;
            state_q <= ST_MUL_LL;
          end else begin
            slot_q  <= final_mix[SLOT_W-1:0];
            probe_q <= '0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_COMPARE;
        end
        ST_COMPARE: begin
          if (slot_empty) begin
            if (can_insert) begin
              total_q       <= total_q + TOTAL_W'(1);
              res_outcome_q <= OUT_INSERTED;
              res_slot_q    <= slot_q;
              res_count_q   <= COUNT_BITS'(1);
            end else begin
              res_outcome_q <= OUT_DROPPED;
              res_slot_q    <= '0;
              res_count_q   <= '0;
            end
            state_q <= ST_DONE;
          end else if (slot_match) begin
            res_outcome_q <= OUT_COUNTED;
            res_slot_q    <= slot_q;
            res_count_q   <= count_next;
            state_q       <= ST_DONE;
          end else if (probe_q == '1) begin
            res_outcome_q <= OUT_DROPPED;
            res_slot_q    <= '0;
            res_count_q   <= '0;
            state_q       <= ST_DONE;
          end else begin
            slot_q  <= slot_q + SLOT_W'(1);
            probe_q <= probe_q + SLOT_W'(1);
            state_q <= ST_READ;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q   <= 1'b1;
            out_outcome_q <= res_outcome_q;
            out_slot_q    <= res_slot_q;
            out_count_q   <= res_count_q;
            out_total_q   <= total_q;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign outcome_o     = out_outcome_q;
  assign slot_index_o  = out_slot_q;
  assign occurrences_o = out_count_q;
  assign edges_held_o  = out_total_q;

endmodule

FILE: rtl/ehc_checker.sv
// Port-level assertions for the edge occurrence hash counter and their bind.
module ehc_checker
  import ehc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [OFFS_W-1:0]     source_offset_i,
  input logic [OFFS_W-1:0]     destination_offset_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [1:0]            outcome_o,
  input logic [SLOT_W-1:0]     slot_index_o,
  input logic [COUNT_BITS-1:0] occurrences_o,
  input logic [TOTAL_W-1:0]    edges_held_o
);

  // A stalled result transaction stays offered with the same payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(outcome_o)
      && $stable(slot_index_o) && $stable(occurrences_o) && $stable(edges_held_o))
    else $error("stalled result transaction changed");

  // A dropped edge reports no slot and no count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OUT_DROPPED) |-> (slot_index_o == '0)
      && (occurrences_o == '0))
    else $error("dropped edge carries a slot or a count");

  // A new edge starts at one occurrence and the table holds at least one edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OUT_INSERTED) |-> (occurrences_o == COUNT_BITS'(1))
      && (edges_held_o != '0))
    else $error("inserted edge has a wrong count or total");

  // Only the three defined outcomes appear, and a counted edge has a nonzero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((outcome_o == OUT_COUNTED) && (occurrences_o != '0))
      || (outcome_o == OUT_INSERTED) || (outcome_o == OUT_DROPPED))
    else $error("invalid outcome or empty count on a counted edge");

endmodule

bind edge_occurrence_hash_counter ehc_checker u_ehc_checker (.*);
